// File: design/hts_pkg.sv
// Package for the heater thermal safety monitor.
// Holds the item, configuration and fault types and the fixed constants.
// No dependencies.
package hts_pkg;

  localparam int TEMP_W  = 16;
  localparam int TIME_W  = 32;
  localparam int DRIVE_W = 8;
  localparam int CFG_W   = 20;
  localparam int LIM_W   = 15;
  localparam int PER_W   = 20;
  localparam int IDX_W   = 3;

  localparam logic signed [TEMP_W-1:0] MIN_TEMP_LIMIT  = 16'sd80;
  localparam logic signed [TEMP_W-1:0] NO_HISTORY_TEMP = -16'sd16;

  localparam logic [LIM_W-1:0]   RST_MAX_TEMP_LIMIT      = 15'd4800;
  localparam logic [LIM_W-1:0]   RST_MAX_STEP_CHANGE     = 15'd160;
  localparam logic [LIM_W-1:0]   RST_HOLD_WINDOW         = 15'd80;
  localparam logic [DRIVE_W-1:0] RST_MIN_DRIVE_FOR_WATCH = 8'd128;
  localparam logic [PER_W-1:0]   RST_HEAT_PERIOD_MS      = 20'd20000;
  localparam logic [LIM_W-1:0]   RST_HEAT_MIN_RISE       = 15'd32;
  localparam logic [LIM_W-1:0]   RST_HOLD_MAX_DROP       = 15'd160;
  localparam logic [PER_W-1:0]   RST_HOLD_PERIOD_MS      = 20'd30000;

  typedef enum logic [2:0] {
    FAULT_OK,
    FAULT_OVER_TEMP,
    FAULT_UNDER_TEMP,
    FAULT_JUMP,
    FAULT_RUNAWAY
  } fault_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_MAX_TEMP_LIMIT,
    CFG_MAX_STEP_CHANGE,
    CFG_HOLD_WINDOW,
    CFG_MIN_DRIVE_FOR_WATCH,
    CFG_HEAT_PERIOD_MS,
    CFG_HEAT_MIN_RISE,
    CFG_HOLD_MAX_DROP,
    CFG_HOLD_PERIOD_MS
  } cfg_idx_t;

  typedef struct packed {
    logic                     mode;
    logic signed [TEMP_W-1:0] meas_temp;
    logic signed [TEMP_W-1:0] set_temp;
    logic [DRIVE_W-1:0]       drive_level;
    logic [TIME_W-1:0]        now_ms;
  } hts_item_t;

  typedef struct packed {
    logic [LIM_W-1:0]   max_temp_limit;
    logic [LIM_W-1:0]   max_step_change;
    logic [LIM_W-1:0]   hold_window;
    logic [DRIVE_W-1:0] min_drive_for_watch;
    logic [PER_W-1:0]   heat_period_ms;
    logic [LIM_W-1:0]   heat_min_rise;
    logic [LIM_W-1:0]   hold_max_drop;
    logic [PER_W-1:0]   hold_period_ms;
  } hts_cfg_t;

endpackage

// File: design/hts_in_if.sv
// Input channel of the heater thermal safety monitor: valid, ready, sample fields.
// No dependencies.
interface hts_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] meas_temp;
  logic signed [15:0] set_temp;
  logic [7:0]         drive_level;
  logic [31:0]        now_ms;

  modport source (output valid, mode, meas_temp, set_temp, drive_level, now_ms,
                  input ready);
  modport sink (input valid, mode, meas_temp, set_temp, drive_level, now_ms,
                output ready);
endinterface

// File: design/hts_out_if.sv
// Result channel of the heater thermal safety monitor: valid, ready, fault code.
// No dependencies.
interface hts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] fault;

  modport source (output valid, fault, input ready);
  modport sink (input valid, fault, output ready);
endinterface

// File: design/heater_thermal_safety_monitor_top.sv
// Top level of the heater thermal safety monitor.
// Depends on hts_pkg, hts_in_if, hts_out_if, hts_cfg_regs and hts_core.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    mode, meas_temp, set_temp, drive_level, now_ms
//   out_ch    out   valid/ready    fault
//   cfg_*     in    cfg_we         cfg_idx, cfg_wdata
//
// One sample per cycle unless the result side stalls.
// Stage one is the input register, the check logic sits between it and the result register.
// Reset: all history and the output stage clear, registers take their default values.
// A stalled result holds stage one; the input side takes a new item whenever stage one drains.
module heater_thermal_safety_monitor_top (
  input  logic                      clk,
  input  logic                      rst_n,
  hts_in_if.sink                    in_ch,
  hts_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [hts_pkg::IDX_W-1:0] cfg_idx,
  input  logic [hts_pkg::CFG_W-1:0] cfg_wdata
);
  import hts_pkg::*;

  hts_item_t s1_r;
  logic      s1_valid_r;
  logic      out_valid_r;
  fault_t    out_fault_r;
  hts_cfg_t  cfg;
  fault_t    fault;
  logic      advance;
  logic      in_xfer;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  hts_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hts_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .item  (s1_r),
    .cfg   (cfg),
    .fault (fault)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r.mode        <= in_ch.mode;
      s1_r.meas_temp   <= in_ch.meas_temp;
      s1_r.set_temp    <= in_ch.set_temp;
      s1_r.drive_level <= in_ch.drive_level;
      s1_r.now_ms      <= in_ch.now_ms;
    end
    if (advance) begin
      out_fault_r <= fault;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.fault = out_fault_r;

`ifndef SYNTH
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result lost after stage advance");
  a_clear_gives_ok: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_r.mode |=> out_fault_r == FAULT_OK)
    else $error("clear item reported a fault");
  a_fault_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_fault_r <= FAULT_RUNAWAY)
    else $error("fault code out of range");
`endif

endmodule

// File: design/hts_cfg_regs.sv
// Configuration register file of the heater thermal safety monitor.
// Depends on hts_pkg.
module hts_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [hts_pkg::IDX_W-1:0]   cfg_idx,
  input  logic [hts_pkg::CFG_W-1:0]   cfg_wdata,
  output hts_pkg::hts_cfg_t           cfg
);
  import hts_pkg::*;

  hts_cfg_t cfg_r;
  hts_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_MAX_TEMP_LIMIT:      cfg_nxt.max_temp_limit      = cfg_wdata[LIM_W-1:0];
        CFG_MAX_STEP_CHANGE:     cfg_nxt.max_step_change     = cfg_wdata[LIM_W-1:0];
        CFG_HOLD_WINDOW:         cfg_nxt.hold_window         = cfg_wdata[LIM_W-1:0];
        CFG_MIN_DRIVE_FOR_WATCH: cfg_nxt.min_drive_for_watch = cfg_wdata[DRIVE_W-1:0];
        CFG_HEAT_PERIOD_MS:      cfg_nxt.heat_period_ms      = cfg_wdata[PER_W-1:0];
        CFG_HEAT_MIN_RISE:       cfg_nxt.heat_min_rise       = cfg_wdata[LIM_W-1:0];
        CFG_HOLD_MAX_DROP:       cfg_nxt.hold_max_drop       = cfg_wdata[LIM_W-1:0];
        CFG_HOLD_PERIOD_MS:      cfg_nxt.hold_period_ms      = cfg_wdata[PER_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_temp_limit      <= RST_MAX_TEMP_LIMIT;
      cfg_r.max_step_change     <= RST_MAX_STEP_CHANGE;
      cfg_r.hold_window         <= RST_HOLD_WINDOW;
      cfg_r.min_drive_for_watch <= RST_MIN_DRIVE_FOR_WATCH;
      cfg_r.heat_period_ms      <= RST_HEAT_PERIOD_MS;
      cfg_r.heat_min_rise       <= RST_HEAT_MIN_RISE;
      cfg_r.hold_max_drop       <= RST_HOLD_MAX_DROP;
      cfg_r.hold_period_ms      <= RST_HOLD_PERIOD_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/hts_core.sv
// Check logic and history state of the heater thermal safety monitor.
// Evaluates one sample per enabled cycle and updates the history registers.
// Depends on hts_pkg.
module hts_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  hts_pkg::hts_item_t item,
  input  hts_pkg::hts_cfg_t  cfg,
  output hts_pkg::fault_t    fault
);
  import hts_pkg::*;

  logic signed [TEMP_W-1:0] last_temp_r, last_temp_nxt;
  logic                     heat_watching_r, heat_watching_nxt;
  logic [TIME_W-1:0]        heat_start_time_r, heat_start_time_nxt;
  logic signed [TEMP_W-1:0] heat_start_temp_r, heat_start_temp_nxt;
  logic                     hold_on_r, hold_on_nxt;
  logic                     hold_armed_r, hold_armed_nxt;
  logic [TIME_W-1:0]        hold_drop_time_r, hold_drop_time_nxt;

  logic signed [TEMP_W:0] cur17;
  logic signed [TEMP_W:0] tgt17;
  logic signed [TEMP_W:0] below;
  logic signed [TEMP_W:0] step;
  logic [TEMP_W:0]        step_abs;
  logic signed [TEMP_W:0] rise;
  logic                   target_on;
  logic                   over_temp;
  logic                   under_temp;
  logic                   jump;
  logic                   heating;
  logic                   in_hold;
  logic                   heat_due;
  logic                   hold_due;
  logic                   drop_big;
  logic [TIME_W-1:0]      heat_elapsed;
  logic [TIME_W-1:0]      hold_elapsed;

  assign cur17      = $signed({item.meas_temp[TEMP_W-1], item.meas_temp});
  assign tgt17      = $signed({item.set_temp[TEMP_W-1], item.set_temp});
  assign below      = tgt17 - cur17;
  assign target_on  = item.set_temp > 16'sd0;
  assign over_temp  = cur17 >= $signed({2'b00, cfg.max_temp_limit});
  assign under_temp = target_on && (item.meas_temp < MIN_TEMP_LIMIT);
  assign step       = cur17 - $signed({last_temp_r[TEMP_W-1], last_temp_r});
  assign step_abs   = step[TEMP_W] ? (TEMP_W+1)'(-step) : (TEMP_W+1)'(step);
  assign jump       = !last_temp_r[TEMP_W-1] && (step_abs > {2'b00, cfg.max_step_change});
  assign heating    = target_on && (below > $signed({2'b00, cfg.hold_window}))
                      && (item.drive_level >= cfg.min_drive_for_watch);
  assign in_hold    = target_on && (below <= $signed({2'b00, cfg.hold_window}));
  assign heat_elapsed = item.now_ms - heat_start_time_r;
  assign hold_elapsed = item.now_ms - hold_drop_time_r;
  assign heat_due   = heat_elapsed >= {{(TIME_W-PER_W){1'b0}}, cfg.heat_period_ms};
  assign hold_due   = hold_elapsed >= {{(TIME_W-PER_W){1'b0}}, cfg.hold_period_ms};
  assign rise       = cur17 - $signed({heat_start_temp_r[TEMP_W-1], heat_start_temp_r});
  assign drop_big   = below > $signed({2'b00, cfg.hold_max_drop});

  always_comb begin
    last_temp_nxt       = last_temp_r;
    heat_watching_nxt   = heat_watching_r;
    heat_start_time_nxt = heat_start_time_r;
    heat_start_temp_nxt = heat_start_temp_r;
    hold_on_nxt         = hold_on_r;
    hold_armed_nxt      = hold_armed_r;
    hold_drop_time_nxt  = hold_drop_time_r;
    fault               = FAULT_OK;
    if (item.mode) begin
      last_temp_nxt     = NO_HISTORY_TEMP;
      heat_watching_nxt = 1'b0;
      hold_on_nxt       = 1'b0;
      hold_armed_nxt    = 1'b0;
    end else if (over_temp) begin
      fault = FAULT_OVER_TEMP;
    end else if (under_temp) begin
      fault = FAULT_UNDER_TEMP;
    end else if (jump) begin
      fault = FAULT_JUMP;
    end else begin
      last_temp_nxt = item.meas_temp;
      if (heating && !heat_watching_r) begin
        heat_watching_nxt   = 1'b1;
        heat_start_time_nxt = item.now_ms;
        heat_start_temp_nxt = item.meas_temp;
      end else if (!heating) begin
        heat_watching_nxt = 1'b0;
      end else if (heat_due) begin
        if (rise < $signed({2'b00, cfg.heat_min_rise})) begin
          fault = FAULT_RUNAWAY;
        end else begin
          heat_start_time_nxt = item.now_ms;
          heat_start_temp_nxt = item.meas_temp;
        end
      end
      if (fault == FAULT_OK) begin
        if (in_hold && !hold_on_r) begin
          hold_on_nxt    = 1'b1;
          hold_armed_nxt = 1'b0;
        end else if (!in_hold && target_on) begin
          hold_on_nxt    = 1'b0;
          hold_armed_nxt = 1'b0;
        end
        if (hold_on_nxt) begin
          if (drop_big) begin
            if (!hold_armed_nxt) begin
              hold_armed_nxt     = 1'b1;
              hold_drop_time_nxt = item.now_ms;
            end else if (hold_due) begin
              fault = FAULT_RUNAWAY;
            end
          end else begin
            hold_armed_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_temp_r       <= NO_HISTORY_TEMP;
      heat_watching_r   <= 1'b0;
      heat_start_time_r <= '0;
      heat_start_temp_r <= '0;
      hold_on_r         <= 1'b0;
      hold_armed_r      <= 1'b0;
      hold_drop_time_r  <= '0;
    end else if (en) begin
      last_temp_r       <= last_temp_nxt;
      heat_watching_r   <= heat_watching_nxt;
      heat_start_time_r <= heat_start_time_nxt;
      heat_start_temp_r <= heat_start_temp_nxt;
      hold_on_r         <= hold_on_nxt;
      hold_armed_r      <= hold_armed_nxt;
      hold_drop_time_r  <= hold_drop_time_nxt;
    end
  end

`ifndef SYNTH
  a_clear_history: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.mode |=> last_temp_r == NO_HISTORY_TEMP && !heat_watching_r
                        && !hold_on_r && !hold_armed_r)
    else $error("history not cleared");
  a_jump_keeps_last: assert property (@(posedge clk) disable iff (!rst_n)
    en && fault == FAULT_JUMP |=> $stable(last_temp_r))
    else $error("jump sample stored");
  a_armed_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    hold_armed_r |-> hold_on_r)
    else $error("hold timer armed outside hold phase");
`endif

endmodule

// File: sim/hts_checker.sv
`timescale 1ns / 100ps
// Fault checker for the heater thermal safety monitor: snoops the sample, result and
// register ports, predicts each fault code and compares it with every result transfer.
// Depends on hts_pkg, hts_in_if and hts_out_if.
module hts_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  hts_in_if                         in_mon,
  hts_out_if                        out_mon,
  input  logic                      cfg_we,
  input  logic [hts_pkg::IDX_W-1:0] cfg_idx,
  input  logic [hts_pkg::CFG_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending
);
  import hts_pkg::*;

  hts_cfg_t                 cfg_q;
  logic signed [TEMP_W-1:0] prev_sample;
  logic                     heat_watch;
  logic [TIME_W-1:0]        heat_mark_ms;
  logic signed [TEMP_W-1:0] heat_mark_temp;
  logic                     hold_on;
  logic                     hold_armed;
  logic [TIME_W-1:0]        drop_mark_ms;
  fault_t                   due_faults[$];

  function automatic fault_t fault_of_sample(hts_item_t s);
    int                cur;
    int                tgt;
    int                below;
    int                diff;
    logic              tgt_on;
    logic              heating;
    logic              hold_ph;
    logic [TIME_W-1:0] elapsed;
    if (s.mode) begin
      prev_sample = NO_HISTORY_TEMP;
      heat_watch  = 1'b0;
      hold_on     = 1'b0;
      hold_armed  = 1'b0;
      return FAULT_OK;
    end
    cur    = s.meas_temp;
    tgt    = s.set_temp;
    tgt_on = tgt > 0;
    below  = tgt - cur;
    if (cur >= int'(cfg_q.max_temp_limit)) return FAULT_OVER_TEMP;
    if (tgt_on && cur < int'(MIN_TEMP_LIMIT)) return FAULT_UNDER_TEMP;
    if (prev_sample >= 0) begin
      diff = cur - int'(prev_sample);
      if (diff < 0) diff = -diff;
      if (diff > int'(cfg_q.max_step_change)) return FAULT_JUMP;
    end
    prev_sample = s.meas_temp;

    heating = tgt_on && below > int'(cfg_q.hold_window) &&
              s.drive_level >= cfg_q.min_drive_for_watch;
    if (heating && !heat_watch) begin
      heat_watch     = 1'b1;
      heat_mark_ms   = s.now_ms;
      heat_mark_temp = s.meas_temp;
    end else if (!heating) begin
      heat_watch = 1'b0;
    end else begin
      elapsed = s.now_ms - heat_mark_ms;
      if (elapsed >= TIME_W'(cfg_q.heat_period_ms)) begin
        if (cur - int'(heat_mark_temp) < int'(cfg_q.heat_min_rise)) return FAULT_RUNAWAY;
        heat_mark_ms   = s.now_ms;
        heat_mark_temp = s.meas_temp;
      end
    end

    hold_ph = tgt_on && below <= int'(cfg_q.hold_window);
    if (hold_ph && !hold_on) begin
      hold_on    = 1'b1;
      hold_armed = 1'b0;
    end else if (!hold_ph && tgt_on) begin
      hold_on    = 1'b0;
      hold_armed = 1'b0;
    end

    if (hold_on) begin
      if (below > int'(cfg_q.hold_max_drop)) begin
        if (!hold_armed) begin
          hold_armed   = 1'b1;
          drop_mark_ms = s.now_ms;
        end else begin
          elapsed = s.now_ms - drop_mark_ms;
          if (elapsed >= TIME_W'(cfg_q.hold_period_ms)) return FAULT_RUNAWAY;
        end
      end else begin
        hold_armed = 1'b0;
      end
    end
    return FAULT_OK;
  endfunction

  always @(posedge clk) begin
    fault_t want;
    if (!rst_n) begin
      cfg_q.max_temp_limit      = RST_MAX_TEMP_LIMIT;
      cfg_q.max_step_change     = RST_MAX_STEP_CHANGE;
      cfg_q.hold_window         = RST_HOLD_WINDOW;
      cfg_q.min_drive_for_watch = RST_MIN_DRIVE_FOR_WATCH;
      cfg_q.heat_period_ms      = RST_HEAT_PERIOD_MS;
      cfg_q.heat_min_rise       = RST_HEAT_MIN_RISE;
      cfg_q.hold_max_drop       = RST_HOLD_MAX_DROP;
      cfg_q.hold_period_ms      = RST_HOLD_PERIOD_MS;
      prev_sample    = NO_HISTORY_TEMP;
      heat_watch     = 1'b0;
      heat_mark_ms   = '0;
      heat_mark_temp = '0;
      hold_on        = 1'b0;
      hold_armed     = 1'b0;
      drop_mark_ms   = '0;
      fail_count     = 0;
      due_faults.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_MAX_TEMP_LIMIT:      cfg_q.max_temp_limit      = cfg_wdata[LIM_W-1:0];
          CFG_MAX_STEP_CHANGE:     cfg_q.max_step_change     = cfg_wdata[LIM_W-1:0];
          CFG_HOLD_WINDOW:         cfg_q.hold_window         = cfg_wdata[LIM_W-1:0];
          CFG_MIN_DRIVE_FOR_WATCH: cfg_q.min_drive_for_watch = cfg_wdata[DRIVE_W-1:0];
          CFG_HEAT_PERIOD_MS:      cfg_q.heat_period_ms      = cfg_wdata[PER_W-1:0];
          CFG_HEAT_MIN_RISE:       cfg_q.heat_min_rise       = cfg_wdata[LIM_W-1:0];
          CFG_HOLD_MAX_DROP:       cfg_q.hold_max_drop       = cfg_wdata[LIM_W-1:0];
          CFG_HOLD_PERIOD_MS:      cfg_q.hold_period_ms      = cfg_wdata[PER_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (due_faults.size() == 0) begin
          $error("fault: transfer with no expected value, actual %0d", out_mon.fault);
          fail_count++;
        end else begin
          want = due_faults.pop_front();
          if (out_mon.fault !== want) begin
            $error("fault mismatch: expected %0d actual %0d", want, out_mon.fault);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        due_faults.push_back(fault_of_sample({in_mon.mode, in_mon.meas_temp,
                                              in_mon.set_temp, in_mon.drive_level,
                                              in_mon.now_ms}));
    end
    pending = due_faults.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the heater thermal safety monitor: drives directed and random samples
// and register settings, stalls both sides, and reports the verdict from hts_checker.
// Depends on hts_pkg, hts_in_if, hts_out_if, hts_checker and the block's RTL.
module tb_top;
  import hts_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_idx;
  logic [CFG_W-1:0]   cfg_wdata;
  int                 fail_count;
  int                 pending;
  int                 sent_count;
  bit                 quiet;
  bit                 long_stall_done;

  hts_in_if  in_ch ();
  hts_out_if out_ch ();

  heater_thermal_safety_monitor_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  hts_checker fault_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side: random back-pressure, one long hold-off once traffic is flowing
  initial begin
    out_ch.ready    = 1'b0;
    long_stall_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ch.ready = 1'b0;
      end else if (!long_stall_done && sent_count >= 120) begin
        out_ch.ready = 1'b0;
        repeat (60) @(negedge clk);
        long_stall_done = 1'b1;
        out_ch.ready = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  function automatic logic signed [15:0] to_temp(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic hts_item_t sample(int cur, int tgt, int drive, logic [31:0] stamp);
    hts_item_t it;
    it.mode        = 1'b0;
    it.meas_temp   = to_temp(cur);
    it.set_temp    = to_temp(tgt);
    it.drive_level = 8'(drive);
    it.now_ms      = stamp;
    return it;
  endfunction

  function automatic hts_item_t noise_item();
    hts_item_t it;
    it.mode        = 1'($urandom_range(0, 1));
    it.meas_temp   = 16'($urandom);
    it.set_temp    = 16'($urandom);
    it.drive_level = 8'($urandom);
    it.now_ms      = $urandom;
    return it;
  endfunction

  function automatic hts_cfg_t pick_field_cfg();
    hts_cfg_t c;
    c.max_temp_limit      = 15'($urandom_range(2000, 8000));
    c.max_step_change     = 15'($urandom_range(40, 400));
    c.hold_window         = 15'($urandom_range(40, 400));
    c.min_drive_for_watch = 8'($urandom_range(50, 200));
    c.heat_period_ms      = 20'($urandom_range(500, 5000));
    c.heat_min_rise       = 15'($urandom_range(5, 60));
    c.hold_max_drop       = 15'($urandom_range(20, 300));
    c.hold_period_ms      = 20'($urandom_range(500, 8000));
    return c;
  endfunction

  task automatic push_item(input hts_item_t it);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.mode        = it.mode;
    in_ch.meas_temp   = it.meas_temp;
    in_ch.set_temp    = it.set_temp;
    in_ch.drive_level = it.drive_level;
    in_ch.now_ms      = it.now_ms;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
  endtask

  task automatic load_cfg(input hts_cfg_t c);
    write_reg(CFG_MAX_TEMP_LIMIT, CFG_W'(c.max_temp_limit));
    write_reg(CFG_MAX_STEP_CHANGE, CFG_W'(c.max_step_change));
    write_reg(CFG_HOLD_WINDOW, CFG_W'(c.hold_window));
    write_reg(CFG_MIN_DRIVE_FOR_WATCH, CFG_W'(c.min_drive_for_watch));
    write_reg(CFG_HEAT_PERIOD_MS, CFG_W'(c.heat_period_ms));
    write_reg(CFG_HEAT_MIN_RISE, CFG_W'(c.heat_min_rise));
    write_reg(CFG_HOLD_MAX_DROP, CFG_W'(c.hold_max_drop));
    write_reg(CFG_HOLD_PERIOD_MS, CFG_W'(c.hold_period_ms));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // heater sessions: steady climbs, stuck heaters, dithering in hold, plus jumps, target changes, noise and clears
  task automatic run_random(input int n_items, input hts_cfg_t c);
    int          done;
    int          cur;
    int          tgt;
    int          len;
    int          stride;
    int          gap_ms;
    int          r;
    bit          stuck;
    logic [31:0] stamp;
    hts_item_t   it;
    stride = (c.max_step_change == 0) ? 4 :
             (c.max_step_change > 300) ? 300 : int'(c.max_step_change);
    gap_ms = int'(c.heat_period_ms > c.hold_period_ms ? c.heat_period_ms : c.hold_period_ms);
    gap_ms = gap_ms / 4 + 1;
    if (gap_ms > 8000) gap_ms = 8000;
    done = 0;
    while (done < n_items) begin
      tgt   = $urandom_range(160, 4000);
      cur   = $urandom_range(80, tgt);
      stamp = $urandom;
      stuck = ($urandom_range(0, 3) == 0);
      len   = $urandom_range(6, 30);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          it = noise_item();
        end else if (r < 8) begin
          it = noise_item();
          it.mode = 1'b1;
        end else begin
          if (r < 12)
            cur = cur + ($urandom_range(0, 1) ? 1 : -1) *
                  int'($urandom_range(stride + 1, 3 * stride));
          else if (stuck)
            cur = cur + int'($urandom_range(0, 2)) - 1;
          else if (cur < tgt - int'(c.hold_window))
            cur = cur + int'($urandom_range(0, stride));
          else
            cur = cur + int'($urandom_range(0, 2 * stride)) - stride;
          cur = int'(to_temp(cur));
          if (r >= 12 && r < 15)
            tgt = $urandom_range(0, 1) ? -int'($urandom_range(0, 500))
                                       : int'($urandom_range(160, 4000));
          if (r % 10 == 0)
            stamp = stamp + $urandom_range(0, 700000);
          else
            stamp = stamp + $urandom_range(0, gap_ms);
          it = sample(cur, tgt,
                      (cur < tgt) ? int'($urandom_range(100, 255)) : int'($urandom_range(0, 127)),
                      stamp);
        end
        push_item(it);
        done++;
      end
    end
  endtask

  initial begin
    hts_item_t it;
    hts_cfg_t  c;
    rst_n             = 1'b0;
    quiet             = 1'b0;
    sent_count        = 0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_MAX_TEMP_LIMIT;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = 1'b0;
    in_ch.meas_temp   = '0;
    in_ch.set_temp    = '0;
    in_ch.drive_level = '0;
    in_ch.now_ms      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed samples at reset settings
    push_item(sample(32767, 0, 0, 0));
    push_item(sample(-32768, 0, 0, 32'hffff_ffff));
    push_item(sample(4000, 0, 255, 10));
    push_item(sample(100, 0, 0, 20));
    it = sample(32767, -32768, 255, 32'hffff_ffff);
    it.mode = 1'b1;
    push_item(it);
    push_item(sample(50, 1000, 0, 30));
    push_item(sample(79, 1, 0, 31));
    push_item(sample(80, 32767, 255, 32'hffff_f000));
    push_item(sample(200, 32767, 255, 32'hffff_f000 + 10000));
    push_item(sample(220, 32767, 255, 32'hffff_f000 + 20000));
    push_item(sample(230, 32767, 255, 32'hffff_f000 + 40000));
    push_item(sample(100, 150, 0, 100000));
    push_item(sample(-50, 0, 0, 101000));
    push_item(sample(-200, 0, 0, 102000));
    push_item(sample(-200, -1, 255, 131999));
    push_item(sample(-200, 0, 0, 132000));
    it = sample(0, 0, 0, 0);
    it.mode = 1'b1;
    push_item(it);
    push_item(sample(1000, 2000, 127, 200000));
    push_item(sample(1160, 2000, 128, 200100));
    push_item(sample(1321, 2000, 128, 200200));
    push_item(sample(4800, 0, 0, 200300));
    push_item(sample(1200, 1250, 0, 200400));

    c = pick_field_cfg();
    drain();
    load_cfg(c);
    run_random(140, c);

    c = '{15'd32767, 15'd32767, 15'd32767, 8'd255, 20'd600000, 15'd32767, 15'd32767,
          20'd600000};
    drain();
    load_cfg(c);
    run_random(40, c);

    c = '0;
    drain();
    load_cfg(c);
    run_random(40, c);

    c = pick_field_cfg();
    drain();
    load_cfg(c);
    run_random(90, c);
    quiet = 1'b1;
    run_random(90, c);

    drain();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
design/hts_pkg.sv
design/hts_in_if.sv
design/hts_out_if.sv
design/hts_cfg_regs.sv
design/hts_core.sv
design/heater_thermal_safety_monitor_top.sv
sim/hts_checker.sv
sim/tb_top.sv
